// ===== rtl/core/tbrl_pkg.sv =====
// Token bucket rate limiter: shared package.
// Widths, register indexes, reset values, payload and pipeline types.
// No dependencies.
package tbrl_pkg;

  // Token values are unsigned fixed point with TOKEN_FRAC_BITS fraction bits
  localparam int TOKEN_W         = 48;
  localparam int TIME_W          = 64;
  localparam int TOKEN_FRAC_BITS = 16;
  localparam int PROD_W          = TOKEN_W + TIME_W;

  // Operand split for the refill multiply
  localparam int HALF_W = 32;

  // Configuration port
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE = 1'b1;

  localparam logic [TOKEN_W-1:0] CAP_RESET  = TOKEN_W'(64'd10 << TOKEN_FRAC_BITS);
  localparam logic [TOKEN_W-1:0] RATE_RESET = TOKEN_W'(64'd1 << TOKEN_FRAC_BITS);
  localparam logic [TOKEN_W-1:0] TOKEN_MAX  = '1;

  // Constant divisor: nanoseconds per second, remainder always below it
  localparam int REM_W = 30;
  localparam logic [REM_W-1:0] NS_PER_SEC = 30'd1000000000;

  // Long division, several quotient bits per pipeline stage
  localparam int QBITS_PER_STAGE = 4;
  localparam int DIV_STAGES      = TOKEN_W / QBITS_PER_STAGE;

  typedef struct packed {
    logic [TIME_W-1:0]  now_time;
    logic [TOKEN_W-1:0] amount;
  } tbrl_in_t;

  typedef struct packed {
    logic               granted;
    logic [TOKEN_W-1:0] tokens_left;
  } tbrl_out_t;

  // Per-request control carried alongside the divider
  typedef struct packed {
    logic               adv;       // time moved forward
    logic               sat;       // refill at or above the token range
    logic               cap_ge;    // capacity covers the amount
    logic [TOKEN_W-1:0] cap_left;  // capacity minus amount
    logic [TOKEN_W-1:0] amount;
  } tbrl_side_t;

  typedef struct packed {
    tbrl_side_t         side;
    logic [REM_W-1:0]   rem;
    logic [TOKEN_W-1:0] quo;       // dividend bits shift out, quotient bits shift in
  } tbrl_div_t;

endpackage

// ===== rtl/core/token_bucket_rate_limiter_top.sv =====
// Token bucket rate limiter: top level.
// Time tracking, refill multiply, bucket update and output skid buffer.
// Depends on tbrl_pkg and tbrl_div_pipe.
//
// Usage:
//   Requests arrive on in_valid/in_ready with a nanosecond timestamp and a
//   token amount; one result (grant flag, tokens left) leaves on
//   out_valid/out_ready for every request, in order.
//   One request is taken every cycle while in_ready is high. A result
//   passes through the input register, elapsed-time stage, partial
//   products, product sum, then the divide-by-1e9 pipeline whose stage
//   count is set by the quotient bits resolved per stage. The bucket
//   level is updated in the cycle the request leaves the divider.
//   Capacity and refill rate are written through cfg_wr_en/cfg_index/
//   cfg_wdata; the user must write them only while the block is empty,
//   which the block does not enforce. Writing capacity refills the bucket
//   and clears the last refill time. Reset loads capacity 10.0, rate 1.0,
//   a full bucket and time zero. A stalled receiver fills the output
//   register and then a one-entry skid buffer; in_ready drops only while
//   the skid buffer is occupied, and the whole pipeline holds until it drains.
module token_bucket_rate_limiter_top import tbrl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tbrl_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tbrl_out_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration and bucket state
  logic [TOKEN_W-1:0] cap_r;
  logic [TOKEN_W-1:0] rate_r;
  logic [TOKEN_W-1:0] level_r;
  logic [TIME_W-1:0]  last_time_r;

  // Pipeline advance
  logic en;
  logic produce;

  // Stage 0: input register
  logic     s0_valid_r;
  tbrl_in_t s0_r;

  // Stage 1: elapsed time
  logic               s1_valid_r;
  logic               s1_adv_r;
  logic [TIME_W-1:0]  s1_elapsed_r;
  logic [TOKEN_W-1:0] s1_amount_r;
  logic               adv_nxt;

  // Stage 2: partial products
  logic                      s2_valid_r;
  logic                      s2_adv_r;
  logic [TOKEN_W-1:0]        s2_amount_r;
  logic [2*HALF_W-1:0]       pp0_r, pp1_r;
  logic [TOKEN_W-1:0]        pp2_r, pp3_r;
  logic [2*HALF_W-1:0]       pp0_nxt, pp1_nxt;
  logic [TOKEN_W-1:0]        pp2_nxt, pp3_nxt;

  // Stage 3: full product
  logic               s3_valid_r;
  logic               s3_adv_r;
  logic [TOKEN_W-1:0] s3_amount_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;

  // Divider
  tbrl_div_t div_in;
  tbrl_div_t tail;
  logic      tail_valid;

  // Bucket update
  logic [TOKEN_W-1:0] add_eff;
  logic [TOKEN_W:0]   sum;
  logic [TOKEN_W:0]   sum_left;
  logic               full;
  logic               sum_ge;
  logic [TOKEN_W-1:0] refilled;
  tbrl_out_t          res;

  // Output register and skid buffer
  logic      out_valid_r;
  tbrl_out_t out_r;
  logic      skid_valid_r;
  tbrl_out_t skid_r;

  assign en       = !skid_valid_r;
  assign in_ready = en;
  assign produce  = en && tail_valid;

  // Time tracking: refill only when time moves forward
  assign adv_nxt = s0_r.now_time > last_time_r;

  // 48 x 64 product cut into partial products at a 32-bit operand split
  assign pp0_nxt = (2*HALF_W)'(rate_r[HALF_W-1:0]) * (2*HALF_W)'(s1_elapsed_r[HALF_W-1:0]);
  assign pp1_nxt = (2*HALF_W)'(rate_r[HALF_W-1:0]) * (2*HALF_W)'(s1_elapsed_r[TIME_W-1:HALF_W]);
  assign pp2_nxt = TOKEN_W'(rate_r[TOKEN_W-1:HALF_W]) * TOKEN_W'(s1_elapsed_r[HALF_W-1:0]);
  assign pp3_nxt = TOKEN_W'(rate_r[TOKEN_W-1:HALF_W]) * TOKEN_W'(s1_elapsed_r[TIME_W-1:HALF_W]);

  assign prod_nxt = PROD_W'(pp0_r)
                  + (PROD_W'(pp1_r) << HALF_W)
                  + (PROD_W'(pp2_r) << HALF_W)
                  + (PROD_W'(pp3_r) << (2*HALF_W));

  // Divider load: saturation check and capacity-side precompute
  always_comb begin
    div_in.side.adv      = s3_adv_r;
    div_in.side.sat      = prod_r[PROD_W-1:TOKEN_W] >= (PROD_W-TOKEN_W)'(NS_PER_SEC);
    div_in.side.cap_ge   = cap_r >= s3_amount_r;
    div_in.side.cap_left = cap_r - s3_amount_r;
    div_in.side.amount   = s3_amount_r;
    div_in.rem           = prod_r[TOKEN_W+REM_W-1:TOKEN_W];
    div_in.quo           = prod_r[TOKEN_W-1:0];
  end

  tbrl_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv_en    (en),
    .in_valid  (s3_valid_r),
    .in_data   (div_in),
    .out_valid (tail_valid),
    .out_data  (tail)
  );

  // Refill, cap at capacity, then grant or refuse
  always_comb begin
    if (!tail.side.adv) begin
      add_eff = '0;
    end else if (tail.side.sat) begin
      add_eff = TOKEN_MAX;
    end else begin
      add_eff = tail.quo;
    end
    sum      = {1'b0, level_r} + {1'b0, add_eff};
    full     = tail.side.adv && (sum >= {1'b0, cap_r});
    sum_ge   = sum >= {1'b0, tail.side.amount};
    sum_left = sum - {1'b0, tail.side.amount};
    refilled = full ? cap_r : sum[TOKEN_W-1:0];
    res.granted = full ? tail.side.cap_ge : sum_ge;
    if (!res.granted) begin
      res.tokens_left = refilled;
    end else if (full) begin
      res.tokens_left = tail.side.cap_left;
    end else begin
      res.tokens_left = sum_left[TOKEN_W-1:0];
    end
  end

  // Configuration and bucket state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      rate_r      <= RATE_RESET;
      level_r     <= CAP_RESET;
      last_time_r <= '0;
    end else begin
      if (cfg_wr_en && (cfg_index == CFG_REFILL_RATE)) begin
        rate_r <= TOKEN_W'(cfg_wdata);
      end
      if (cfg_wr_en && (cfg_index == CFG_CAPACITY)) begin
        cap_r       <= TOKEN_W'(cfg_wdata);
        level_r     <= TOKEN_W'(cfg_wdata);
        last_time_r <= '0;
      end else begin
        if (produce) begin
          level_r <= res.tokens_left;
        end
        if (en && s0_valid_r && adv_nxt) begin
          last_time_r <= s0_r.now_time;
        end
      end
    end
  end

  // Front pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Front pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r         <= in_data;
      s1_adv_r     <= adv_nxt;
      s1_elapsed_r <= s0_r.now_time - last_time_r;
      s1_amount_r  <= s0_r.amount;
      s2_adv_r     <= s1_adv_r;
      s2_amount_r  <= s1_amount_r;
      pp0_r        <= pp0_nxt;
      pp1_r        <= pp1_nxt;
      pp2_r        <= pp2_nxt;
      pp3_r        <= pp3_nxt;
      s3_adv_r     <= s2_adv_r;
      s3_amount_r  <= s2_amount_r;
      prod_r       <= prod_nxt;
    end
  end

  // Output register with one-entry skid buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= produce;
        if (produce) begin
          out_r <= res;
        end
      end
    end else if (produce) begin
      skid_valid_r <= 1'b1;
      skid_r       <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Bucket never holds more than its capacity
  a_level_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= cap_r)
    else $error("token level above capacity");

  // Skid buffer only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid buffer holds a result while output is empty");

  // A result produced against a stalled receiver lands in the skid buffer
  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    $past(produce && out_valid_r && !out_ready) |-> skid_valid_r)
    else $error("result lost while receiver stalled");

  // Last refill time only moves forward, except on a capacity write
  a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cfg_wr_en && (cfg_index == CFG_CAPACITY)))
      |-> (last_time_r >= $past(last_time_r)))
    else $error("last refill time went backwards");
`endif

endmodule

// ===== rtl/core/tbrl_div_pipe.sv =====
// Token bucket rate limiter: pipelined divide by one second in nanoseconds.
// Restoring long division, QBITS_PER_STAGE quotient bits per stage.
// Depends on tbrl_pkg.
module tbrl_div_pipe import tbrl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv_en,
  input  logic      in_valid,
  input  tbrl_div_t in_data,
  output logic      out_valid,
  output tbrl_div_t out_data
);

  logic [DIV_STAGES:0] vld_r;
  tbrl_div_t           st_r   [0:DIV_STAGES];
  tbrl_div_t           st_nxt [1:DIV_STAGES];

  // One group of compare-and-subtract steps
  function automatic tbrl_div_t div_step(input tbrl_div_t d);
    tbrl_div_t        r;
    logic [REM_W:0]   trial;
    r = d;
    for (int i = 0; i < QBITS_PER_STAGE; i++) begin
      trial = {r.rem, r.quo[TOKEN_W-1]};
      if (trial >= {1'b0, NS_PER_SEC}) begin
        r.rem = REM_W'(trial - {1'b0, NS_PER_SEC});
        r.quo = {r.quo[TOKEN_W-2:0], 1'b1};
      end else begin
        r.rem = trial[REM_W-1:0];
        r.quo = {r.quo[TOKEN_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  always_comb begin
    for (int k = 1; k <= DIV_STAGES; k++) begin
      st_nxt[k] = div_step(st_r[k-1]);
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv_en) begin
      vld_r <= {vld_r[DIV_STAGES-1:0], in_valid};
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (adv_en) begin
      st_r[0] <= in_data;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[DIV_STAGES];
  assign out_data  = st_r[DIV_STAGES];

endmodule
